// ===== hw/rtl/ebs_pkg.sv =====
// Shared types and constants of the emission burst scheduler.
package ebs_pkg;

  localparam int BURST_COUNT = 4;
  localparam int SLOTS       = 4;
  localparam int BIDX_W      = 2;
  localparam logic [BIDX_W-1:0] LAST_BURST = BIDX_W'(BURST_COUNT - 1);

  localparam int TIME_W  = 33;
  localparam int BACC_W  = 25;
  localparam int STEP_W  = 20;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 64;

  localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};
  localparam logic [BACC_W-1:0] MAX_BACC = {BACC_W{1'b1}};

  typedef enum logic [2:0] {
    REG_RUN_LENGTH,
    REG_LOOP_ENABLE,
    REG_EMIT_PERIOD,
    REG_BURST_A,
    REG_BURST_B,
    REG_BURST_C,
    REG_BURST_D
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_EMIT,
    S_DIV,
    S_BURST,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/ebs_if.sv =====
// Valid/ready channel interfaces for tick beats and result beats.
interface ebs_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] time_step;

  modport source (output valid, output time_step, input ready);
  modport sink   (input valid, input time_step, output ready);
endinterface

interface ebs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] spawn_count;
  logic        finished;

  modport source (output valid, output spawn_count, output finished, input ready);
  modport sink   (input valid, input spawn_count, input finished, output ready);
endinterface

// ===== hw/rtl/ebs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ebs_div
  import ebs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [31:0]       divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient,
  output logic [31:0]       remainder
);

  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [32:0]       shifted;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, quo_r[TIME_W-1]};
    fits     = shifted >= {1'b0, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'(TIME_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[TIME_W-2:0], fits};
      rem_nxt = fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/emission_burst_scheduler_core.sv =====
// Top level of the emission burst scheduler: sequencer, timers and burst state.
// With a nonzero emit period a result beat runs through these steps after its tick beat is
// accepted: the run-time check, the emit accumulator, the bit-serial divider that splits
// the accumulator by the period, each burst slot in turn, and the hand-off to the output
// register. The input is ready again only after the hand-off, so a new tick is not taken
// before the last one is through. With a zero period the divider is skipped. A finished
// tick goes from the run-time check straight to the hand-off. While an older result still
// waits for the sink, a new result is held in the last sequencer step, which stalls the
// sequencer until the sink takes the older result.
// The input is not ready while a beat is in work, but a new beat is taken while
// the previous result still waits in the output register.
module emission_burst_scheduler_core
  import ebs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ebs_in_if.sink              in_ch,
  ebs_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  function automatic logic [COUNT_W-1:0] sat_add16(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [31:0]       run_length_r, run_length_nxt;
  logic              loop_r, loop_nxt;
  logic [31:0]       period_r, period_nxt;
  logic [CFG_W-1:0]  word_r [SLOTS], word_nxt [SLOTS];

  logic [TIME_W-1:0] run_time_r, run_time_nxt;
  logic [TIME_W-1:0] emit_acc_r, emit_acc_nxt;
  logic [BACC_W-1:0] bacc_r [SLOTS], bacc_nxt [SLOTS];
  logic [SLOTS-1:0]  bdone_r, bdone_nxt;

  logic [STEP_W-1:0]  dt_r, dt_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               fin_r, fin_nxt;
  logic [BIDX_W-1:0]  idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_fin_r, out_fin_nxt;

  logic              in_ready;
  logic              in_accept;
  logic              div_start;
  logic              out_load;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;
  logic [31:0]       div_rem;

  logic [TIME_W:0]   rt_sum;
  logic [TIME_W-1:0] rt_sat;
  logic              len_hit;
  logic [TIME_W:0]   ea_sum;
  logic [TIME_W-1:0] ea_sat;
  logic [CFG_W-1:0]  cur_word;
  logic [23:0]       cur_start;
  logic [23:0]       cur_rep;
  logic [15:0]       cur_amt;
  logic              cur_active;
  logic [BACC_W:0]   b_sum;
  logic [BACC_W-1:0] b_sat;
  logic              b_fire;
  logic [BIDX_W-1:0] cfg_slot;

  ebs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ea_sat),
    .divisor   (period_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_TIME;
      S_TIME:  state_nxt = (len_hit && !loop_r) ? S_DONE : S_EMIT;
      S_EMIT:  state_nxt = (period_r != '0) ? S_DIV : S_BURST;
      S_DIV:   if (div_done) state_nxt = S_BURST;
      S_BURST: if (idx_r == LAST_BURST) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    div_start = (state_r == S_EMIT) && (period_r != '0);
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign in_accept = in_ch.valid && in_ready;

  // Datapath.
  always_comb begin
    rt_sum  = {1'b0, run_time_r} + (TIME_W+1)'(dt_r);
    rt_sat  = rt_sum[TIME_W] ? MAX_TIME : rt_sum[TIME_W-1:0];
    len_hit = rt_sat >= {1'b0, run_length_r};
    ea_sum  = {1'b0, emit_acc_r} + (TIME_W+1)'(dt_r);
    ea_sat  = ea_sum[TIME_W] ? MAX_TIME : ea_sum[TIME_W-1:0];

    cur_word   = word_r[idx_r];
    cur_start  = cur_word[63:40];
    cur_rep    = cur_word[39:16];
    cur_amt    = cur_word[15:0];
    cur_active = run_time_r >= TIME_W'(cur_start);
    b_sum      = {1'b0, bacc_r[idx_r]} + (BACC_W+1)'(dt_r);
    b_sat      = b_sum[BACC_W] ? MAX_BACC : b_sum[BACC_W-1:0];
    b_fire     = b_sat >= BACC_W'(cur_rep);
    cfg_slot   = BIDX_W'(cfg_index - REG_BURST_A);

    run_length_nxt = run_length_r;
    loop_nxt       = loop_r;
    period_nxt     = period_r;
    word_nxt       = word_r;
    run_time_nxt   = run_time_r;
    emit_acc_nxt   = emit_acc_r;
    bacc_nxt       = bacc_r;
    bdone_nxt      = bdone_r;
    dt_nxt         = dt_r;
    total_nxt      = total_r;
    fin_nxt        = fin_r;
    idx_nxt        = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          dt_nxt    = in_ch.time_step;
          total_nxt = '0;
          fin_nxt   = 1'b0;
        end
      end
      S_TIME: begin
        idx_nxt      = '0;
        run_time_nxt = rt_sat;
        if (len_hit) begin
          if (loop_r) begin
            run_time_nxt = '0;
            emit_acc_nxt = TIME_W'(period_r);
            for (int b = 0; b < SLOTS; b++) begin
              bacc_nxt[b] = BACC_W'(word_r[b][39:16]);
            end
            bdone_nxt = '0;
          end else begin
            fin_nxt = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (period_r == '0) begin
          emit_acc_nxt = ea_sat;
        end
      end
      S_DIV: begin
        if (div_done) begin
          emit_acc_nxt = TIME_W'(div_rem);
          total_nxt    = (div_quo[TIME_W-1:COUNT_W] != '0) ? {COUNT_W{1'b1}}
                                                           : div_quo[COUNT_W-1:0];
        end
      end
      S_BURST: begin
        idx_nxt = idx_r + 1'b1;
        if (cur_active) begin
          if (cur_rep == '0) begin
            if (!bdone_r[idx_r]) begin
              bdone_nxt[idx_r] = 1'b1;
              total_nxt        = sat_add16(total_r, cur_amt);
            end
          end else if (b_fire) begin
            bacc_nxt[idx_r] = b_sat - BACC_W'(cur_rep);
            total_nxt       = sat_add16(total_r, cur_amt);
          end else begin
            bacc_nxt[idx_r] = b_sat;
          end
        end
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RUN_LENGTH:  run_length_nxt = cfg_data[31:0];
        REG_LOOP_ENABLE: loop_nxt = cfg_data[0];
        REG_EMIT_PERIOD: begin
          period_nxt   = cfg_data[31:0];
          emit_acc_nxt = TIME_W'(cfg_data[31:0]);
        end
        REG_BURST_A, REG_BURST_B, REG_BURST_C, REG_BURST_D: begin
          word_nxt[cfg_slot]  = cfg_data;
          bacc_nxt[cfg_slot]  = BACC_W'(cfg_data[39:16]);
          bdone_nxt[cfg_slot] = 1'b0;
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_fin_nxt   = out_fin_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = fin_r ? '0 : total_r;
      out_fin_nxt   = fin_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_length_r <= '0;
      loop_r       <= 1'b0;
      period_r     <= '0;
      run_time_r   <= '0;
      emit_acc_r   <= '0;
      bdone_r      <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int b = 0; b < SLOTS; b++) begin
        word_r[b] <= '0;
        bacc_r[b] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      run_length_r <= run_length_nxt;
      loop_r       <= loop_nxt;
      period_r     <= period_nxt;
      run_time_r   <= run_time_nxt;
      emit_acc_r   <= emit_acc_nxt;
      bdone_r      <= bdone_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      word_r       <= word_nxt;
      bacc_r       <= bacc_nxt;
    end
    dt_r        <= dt_nxt;
    total_r     <= total_nxt;
    fin_r       <= fin_nxt;
    out_count_r <= out_count_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.spawn_count = out_count_r;
  assign out_ch.finished    = out_fin_r;

endmodule

// ===== hw/rtl/ebs_checker.sv =====
// Port-level assertions for the emission burst scheduler and their bind.
module ebs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] spawn_count,
  input logic        finished
);

  a_finished_no_spawn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> spawn_count == 16'd0)
    else $error("finished beat carries spawns");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(spawn_count) && $stable(finished))
    else $error("stalled result beat changed");

endmodule

bind emission_burst_scheduler_core ebs_checker u_ebs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .spawn_count (out_ch.spawn_count),
  .finished    (out_ch.finished)
);
